// ===== sv/obuf_pkg.sv =====
// Shared types and constants for the OBU finder.
package obuf_pkg;

    localparam int POS_W = 25;
    localparam int OFF_W = 24;
    localparam int LEN_W = 25;
    localparam int SIZE_W = 56;
    localparam int LEB_CNT_W = 3;
    localparam int TYPE_W = 4;
    localparam int M_TDATA_W = 56;

    localparam logic [POS_W-1:0] MAX_PACKET_BYTES = 25'd16777216;
    localparam logic [LEB_CNT_W-1:0] LEB_LAST_BYTE = 3'd7;

    typedef enum logic [2:0] {
        PH_HEADER       = 3'd0,
        PH_EXT_SIZED    = 3'd1,
        PH_EXT_SIZELESS = 3'd2,
        PH_LEB          = 3'd3,
        PH_PAYLOAD      = 3'd4,
        PH_SIZELESS     = 3'd5,
        PH_DONE         = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND          = 3'd0,
        ST_FORBIDDEN      = 3'd1,
        ST_TRUNCATED      = 3'd2,
        ST_LEB_LONG       = 3'd3,
        ST_EXCEEDS        = 3'd4,
        ST_SIZELESS_WRONG = 3'd5,
        ST_NONE           = 3'd6
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0] hit_length;
        logic [OFF_W-1:0] hit_offset;
        status_t          status;
        logic             found;
    } result_t;

endpackage

// ===== sv/obuf_parser.sv =====
// Per-packet OBU header walker: one byte per step, at most one result per step.
module obuf_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    input  logic [obuf_pkg::TYPE_W-1:0]  target_type,
    output logic                         res_valid,
    output obuf_pkg::result_t            res
);
    import obuf_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       start_reg, start_next;
    logic [TYPE_W-1:0]      type_reg, type_next;
    logic [LEB_CNT_W-1:0]   leb_cnt_reg, leb_cnt_next;
    logic [SIZE_W-1:0]      payload_reg, payload_next;

    logic [SIZE_W-1:0]      leb_val;
    logic [SIZE_W-1:0]      pay_dec;
    logic [5:0]             leb_pos;
    logic [LEN_W-1:0]       unit_len;
    logic                   complete;
    status_t                emit_status;

    // Offset of the reported OBU: a header byte starts its own unit.
    function automatic logic [OFF_W-1:0] start_reg_sel(phase_t ph, logic [POS_W-1:0] pos,
                                                       logic [POS_W-1:0] start);
        logic [POS_W-1:0] s;
        s = (ph == PH_HEADER) ? pos : start;
        return s[OFF_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            start_reg   <= '0;
            type_reg    <= '0;
            leb_cnt_reg <= '0;
            payload_reg <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            type_reg    <= type_next;
            leb_cnt_reg <= leb_cnt_next;
            payload_reg <= payload_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        start_next   = start_reg;
        type_next    = type_reg;
        leb_cnt_next = leb_cnt_reg;
        payload_next = payload_reg;
        res_valid    = 1'b0;
        emit_status  = ST_NONE;
        complete     = 1'b0;

        // Place the next seven size bits above those already gathered.
        leb_pos = 6'({3'b000, leb_cnt_reg} * 6'd7);
        leb_val = payload_reg;
        leb_val[leb_pos +: 7] = data_byte[6:0];
        pay_dec = payload_reg - SIZE_W'(1);

        case (phase_reg)
            PH_HEADER: begin
                start_next = pos_reg;
                if (data_byte[7]) begin
                    res_valid   = 1'b1;
                    emit_status = ST_FORBIDDEN;
                    phase_next  = PH_DONE;
                end else begin
                    type_next    = data_byte[6:3];
                    leb_cnt_next = '0;
                    payload_next = '0;
                    if (data_byte[2]) begin
                        phase_next = data_byte[1] ? PH_EXT_SIZED : PH_EXT_SIZELESS;
                    end else if (data_byte[1]) begin
                        phase_next = PH_LEB;
                    end else if (data_byte[6:3] == target_type) begin
                        phase_next = PH_SIZELESS;
                    end else begin
                        res_valid   = 1'b1;
                        emit_status = ST_SIZELESS_WRONG;
                        phase_next  = PH_DONE;
                    end
                end
            end
            PH_EXT_SIZED: begin
                phase_next = PH_LEB;
            end
            PH_EXT_SIZELESS: begin
                if (type_reg == target_type) begin
                    phase_next = PH_SIZELESS;
                end else begin
                    res_valid   = 1'b1;
                    emit_status = ST_SIZELESS_WRONG;
                    phase_next  = PH_DONE;
                end
            end
            PH_LEB: begin
                payload_next = leb_val;
                leb_cnt_next = leb_cnt_reg + LEB_CNT_W'(1);
                if (data_byte[7]) begin
                    if (leb_cnt_reg == LEB_LAST_BYTE && !last_byte) begin
                        res_valid   = 1'b1;
                        emit_status = ST_LEB_LONG;
                        phase_next  = PH_DONE;
                    end
                end else if (leb_val == '0) begin
                    complete = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                payload_next = pay_dec;
                if (pay_dec == '0) begin
                    complete = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Sized OBU ends on this byte: report it if it matches, else walk on.
        if (complete) begin
            if (type_reg == target_type) begin
                res_valid   = 1'b1;
                emit_status = ST_FOUND;
                phase_next  = PH_DONE;
            end else begin
                phase_next = PH_HEADER;
            end
        end

        pos_next = (pos_reg < MAX_PACKET_BYTES) ? pos_reg + POS_W'(1) : pos_reg;
        unit_len = pos_reg + LEN_W'(1) - start_next;

        if (last_byte) begin
            if (!res_valid) begin
                res_valid = 1'b1;
                case (phase_next)
                    PH_HEADER:       emit_status = ST_NONE;
                    PH_EXT_SIZED,
                    PH_EXT_SIZELESS,
                    PH_LEB:          emit_status = ST_TRUNCATED;
                    PH_PAYLOAD:      emit_status = ST_EXCEEDS;
                    PH_SIZELESS:     emit_status = ST_FOUND;
                    default:         res_valid   = 1'b0;
                endcase
            end
            // Ready for the next packet.
            phase_next   = PH_HEADER;
            pos_next     = '0;
            start_next   = '0;
            type_next    = '0;
            leb_cnt_next = '0;
            payload_next = '0;
        end

        res.found      = (emit_status == ST_FOUND);
        res.status     = emit_status;
        res.hit_offset = (emit_status == ST_FOUND) ? start_reg_sel(phase_reg, pos_reg, start_reg)
                                                   : '0;
        res.hit_length = (emit_status == ST_FOUND) ? unit_len : '0;
    end

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last_byte && phase_reg != PH_DONE |-> res_valid)
        else $error("packet end without a result");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last_byte |=> phase_reg == PH_HEADER && pos_reg == '0)
        else $error("parser not cleared after packet end");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_PACKET_BYTES)
        else $error("byte position beyond saturation limit");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> payload_reg != '0)
        else $error("payload phase with nothing left to skip");

endmodule

// ===== sv/av1_obu_sequence_header_finder_unit.sv =====
// Top level of the AV1 OBU finder: stream ports, config register, I/O registers.
//
// Usage:
//   Feed the bytes of one low-overhead AV1 packet on the s_ channel, one byte
//   per transaction in s_tdata[7:0], with s_tlast high on the final byte.
//   The block walks the OBU headers, skips extension bytes and payloads and
//   returns exactly one result transaction per packet on the m_ channel: the
//   offset and length of the first OBU whose type equals the target, or an
//   error status. The result comes on the byte that decides it, or at the
//   packet's last byte at the latest; later bytes of that packet give none.
//   The target type is written through cfg_wr_en / cfg_wr_data while idle.
// Throughput and pipeline:
//   One byte per cycle sustained while results are taken on the m_ channel;
//   the whole per-byte step (header decode, leb128 gathering, 56-bit payload
//   countdown) sits between the input register and the result register.
//   m_tvalid rises once the causing byte's step loads the result register.
// Reset and stall:
//   aresetn (synchronous, active low) empties both registers, clears the
//   parser for a new packet and sets the target type to 1 (sequence header).
//   While m_tready is low with a result waiting, hold the result and the byte
//   in the input register; s_tready drops once that register is full.
module av1_obu_sequence_header_finder_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [7:0] data_byte
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,
    input  logic                                 s_tlast,
    // m_tdata: [0] found, [3:1] status, [27:4] hit_offset, [52:28] hit_length,
    // [55:53] zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [obuf_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [obuf_pkg::TYPE_W-1:0]          cfg_wr_data
);
    import obuf_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic [TYPE_W-1:0]    target_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;

    logic                 advance;
    logic                 res_valid;
    result_t              res;

    // Step the parser when a byte waits and the result register can take one.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TYPE_W'(1);
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    obuf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .target_type (target_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register: drop on a taken transaction, load on a new result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), out_res_reg};

endmodule

// ===== tb/tb_av1_obu_sequence_header_finder_unit.sv =====
// Self-checking testbench for the AV1 OBU finder: directed packets, then random traffic.
`timescale 1ns / 100ps

module tb_av1_obu_sequence_header_finder_unit;
    import obuf_pkg::*;

    // Cycles to let the two-stage pipeline empty before a register write or the end.
    localparam int DRAIN_CYCLES = 6;
    // Upper bound on cycles spent waiting for outstanding results in one drain.
    localparam int DRAIN_GUARD = 5000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] data_byte
    logic                 s_tlast;    // last_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // [0] found, [3:1] status, [27:4] hit_offset,
                                      // [52:28] hit_length, [55:53] zero
    logic                 cfg_wr_en;
    logic [TYPE_W-1:0]    cfg_wr_data;

    av1_obu_sequence_header_finder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the parser: target register and per-packet walk state.
    // The walk state is updated once per accepted input transaction.
    // ------------------------------------------------------------------
    logic [TYPE_W-1:0] target_type = 4'd1;
    phase_t            walk_phase  = PH_HEADER;
    logic [POS_W-1:0]  walk_pos    = '0;
    logic [POS_W-1:0]  walk_start  = '0;
    logic [TYPE_W-1:0] walk_type   = '0;
    logic [5:0]        leb_shift   = '0;
    logic [SIZE_W-1:0] bytes_left  = '0;

    // Results still owed by the block, oldest first.
    result_t pending_reports[$];

    logic [7:0] pkt[$];           // packet under construction
    int  bytes_fed       = 0;
    int  mismatch_count  = 0;
    bit  quiet_flow      = 1'b0;  // when set, neither side idles

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $error("timeout: traffic never completed");
        $display("TEST FAILED");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_span();
        int r;
        if (quiet_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // Build one result; offset and length only travel with a find.
    function automatic result_t make_report(input status_t st, input logic [63:0] off,
                                            input logic [63:0] len);
        result_t r;
        r.found      = (st == ST_FOUND);
        r.status     = st;
        r.hit_offset = (st == ST_FOUND) ? off[OFF_W-1:0] : '0;
        r.hit_length = (st == ST_FOUND) ? len[LEN_W-1:0] : '0;
        return r;
    endfunction

    // A sized OBU ends at byte idx: report it if it is the target, else go on
    // with the next header.
    function automatic bit close_unit(input logic [POS_W-1:0] idx, output result_t r);
        r = '0;
        if (walk_type == target_type) begin
            r = make_report(ST_FOUND, 64'(walk_start),
                            64'(idx) + 64'd1 - 64'(walk_start));
            walk_phase = PH_DONE;
            return 1'b1;
        end
        walk_phase = PH_HEADER;
        return 1'b0;
    endfunction

    // Advance the shadow parser by one byte and queue the result it causes.
    task automatic obu_walk_step(input logic [7:0] b, input logic lst);
        logic [POS_W-1:0] idx;
        logic [63:0]      acc;
        bit               emitted;
        result_t          rep;
        idx     = walk_pos;
        emitted = 1'b0;
        rep     = '0;
        case (walk_phase)
            PH_HEADER: begin
                walk_start = idx;
                if (b[7]) begin
                    // Forbidden bit set: the packet is dead.
                    rep        = make_report(ST_FORBIDDEN, 0, 0);
                    walk_phase = PH_DONE;
                    emitted    = 1'b1;
                end else begin
                    walk_type  = b[6:3];
                    leb_shift  = '0;
                    bytes_left = '0;
                    if (b[2]) begin
                        walk_phase = b[1] ? PH_EXT_SIZED : PH_EXT_SIZELESS;
                    end else if (b[1]) begin
                        walk_phase = PH_LEB;
                    end else if (walk_type == target_type) begin
                        walk_phase = PH_SIZELESS;
                    end else begin
                        rep        = make_report(ST_SIZELESS_WRONG, 0, 0);
                        walk_phase = PH_DONE;
                        emitted    = 1'b1;
                    end
                end
            end
            PH_EXT_SIZED: begin
                walk_phase = PH_LEB;
            end
            PH_EXT_SIZELESS: begin
                if (walk_type == target_type) begin
                    walk_phase = PH_SIZELESS;
                end else begin
                    rep        = make_report(ST_SIZELESS_WRONG, 0, 0);
                    walk_phase = PH_DONE;
                    emitted    = 1'b1;
                end
            end
            PH_LEB: begin
                // Gather seven size bits per byte, low group first.
                acc        = 64'(b[6:0]) << leb_shift;
                bytes_left = bytes_left | acc[SIZE_W-1:0];
                leb_shift  = leb_shift + 6'd7;
                if (b[7]) begin
                    if (leb_shift >= 6'(SIZE_W) && !lst) begin
                        rep        = make_report(ST_LEB_LONG, 0, 0);
                        walk_phase = PH_DONE;
                        emitted    = 1'b1;
                    end
                end else if (bytes_left == '0) begin
                    emitted = close_unit(idx, rep);
                end else begin
                    walk_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) emitted = close_unit(idx, rep);
            end
            default: ;
        endcase

        if (walk_pos < MAX_PACKET_BYTES) walk_pos = walk_pos + 1'b1;

        if (lst) begin
            // The packet ends here: settle it if nothing was reported yet.
            if (!emitted) begin
                emitted = 1'b1;
                case (walk_phase)
                    PH_HEADER:       rep = make_report(ST_NONE, 0, 0);
                    PH_EXT_SIZED,
                    PH_EXT_SIZELESS,
                    PH_LEB:          rep = make_report(ST_TRUNCATED, 0, 0);
                    PH_PAYLOAD:      rep = make_report(ST_EXCEEDS, 0, 0);
                    PH_SIZELESS:     rep = make_report(ST_FOUND, 64'(walk_start),
                                                       64'(idx) + 64'd1 - 64'(walk_start));
                    default:         emitted = 1'b0;
                endcase
            end
            walk_phase = PH_HEADER;
            walk_pos   = '0;
            walk_start = '0;
            walk_type  = '0;
            leb_shift  = '0;
            bytes_left = '0;
        end

        if (emitted) begin
            pending_reports.push_back(rep);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. Every task is entered and left at a falling edge; s_tvalid
    // may still be high on return, so drop it before any wait that is not
    // another byte.
    // ------------------------------------------------------------------
    task automatic feed_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        // Hold the transaction until the block takes it.
        do @(posedge aclk); while (!s_tready);
        obu_walk_step(b, lst);
        bytes_fed++;
        @(negedge aclk);
    endtask

    task automatic feed_packet();
        for (int i = 0; i < pkt.size(); i++) feed_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Wait for every owed result, then let the pipeline run empty.
    task automatic wait_quiet();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0 && guard < DRAIN_GUARD) begin
            @(negedge aclk);
            guard++;
        end
        if (pending_reports.size() != 0) begin
            $error("%0d expected results never arrived", pending_reports.size());
            mismatch_count++;
            pending_reports.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write the target type while the block is idle.
    task automatic set_target(input logic [TYPE_W-1:0] t);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        target_type  = t;
    endtask

    // ------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------
    // Append one OBU: header, optional extension byte, optional leb128 size
    // (sometimes padded with zero groups up to eight bytes), then payload.
    task automatic append_obu(input logic [3:0] typ, input bit ext, input bit sized,
                              input int unsigned size);
        int unsigned groups;
        int unsigned total;
        pkt.push_back({1'b0, typ, ext, sized, 1'($urandom)});
        if (ext) pkt.push_back(8'($urandom));
        if (sized) begin
            groups = 1;
            while (groups < 8 && (size >> (7 * groups)) != 0) groups++;
            total = groups;
            if ($urandom_range(0, 4) == 0) total = $urandom_range(groups, 8);
            for (int i = 0; i < total; i++)
                pkt.push_back({(i < total - 1) ? 1'b1 : 1'b0, 7'(size >> (7 * i))});
        end
        repeat (size) pkt.push_back(8'($urandom));
    endtask

    // Well-formed packet: one to four OBUs, the target type often among them,
    // a sizeless OBU only at the tail, sometimes junk after it.
    task automatic build_stream_packet();
        int          n;
        int          r;
        logic [3:0]  typ;
        bit          sized;
        int unsigned size;
        pkt.delete();
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            typ   = ($urandom_range(0, 2) == 0) ? target_type : 4'($urandom);
            sized = (k < n - 1) || ($urandom_range(0, 5) != 0);
            r     = $urandom_range(0, 99);
            size  = (r < 60) ? $urandom_range(0, 6) :
                    (r < 96) ? $urandom_range(7, 40) : $urandom_range(128, 200);
            append_obu(typ, $urandom_range(0, 2) == 0, sized, size);
            if (!sized) break;
        end
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
    endtask

    // Damaged packet: cut short, pure noise, runaway leb128, or oversize length.
    task automatic build_broken_packet();
        int keep;
        bit ext;
        case ($urandom_range(0, 3))
            0: begin
                build_stream_packet();
                keep = $urandom_range(1, pkt.size());
                while (pkt.size() > keep) void'(pkt.pop_back());
            end
            1: begin
                pkt.delete();
                repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
            end
            2: begin
                pkt.delete();
                ext = $urandom_range(0, 1);
                pkt.push_back({1'b0, 4'($urandom), ext, 1'b1, 1'($urandom)});
                if (ext) pkt.push_back(8'($urandom));
                repeat ($urandom_range(7, 9)) pkt.push_back({1'b1, 7'($urandom)});
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
            end
            default: begin
                pkt.delete();
                pkt.push_back({1'b0, 4'($urandom), 1'b0, 1'b1, 1'($urandom)});
                repeat (7) pkt.push_back({1'b1, 7'($urandom)});
                pkt.push_back({1'b0, 7'($urandom_range(1, 127))});
                repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests (the directed ones keep the reset target, the sequence header type)
    // ------------------------------------------------------------------
    task automatic test_finds();
        // Empty temporal delimiter, then a sequence header; one byte trails the find.
        pkt = '{8'h12, 8'h00, 8'h0A, 8'h01, 8'hAB, 8'hFF};
        feed_packet();
        // Sizeless sequence header runs to the packet end.
        pkt = '{8'h08, 8'h11};
        feed_packet();
    endtask

    task automatic test_error_statuses();
        pkt = '{8'h80};                              // forbidden bit
        feed_packet();
        pkt = '{8'h34, 8'h00};                       // sizeless, other type, extension
        feed_packet();
        pkt = '{8'h12, 8'hFF, 8'hFF, 8'hFF, 8'hFF,   // size field longer than 8 bytes
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        feed_packet();
        pkt = '{8'h16, 8'h00};                       // ends on the extension byte
        feed_packet();
        pkt = '{8'h12, 8'h05, 8'h01};                // ends inside the payload
        feed_packet();
        pkt = '{8'h12, 8'h00};                       // no matching OBU
        feed_packet();
    endtask

    // Several target settings, the extremes first; one phase runs without idling.
    task automatic test_random_traffic();
        logic [TYPE_W-1:0] plan [6];
        int                start_bytes;
        plan = '{4'd0, 4'd15, 4'd1, 4'($urandom), 4'($urandom), 4'($urandom)};
        foreach (plan[p]) begin
            quiet_flow = (p == 2);
            set_target(plan[p]);
            start_bytes = bytes_fed;
            while (bytes_fed - start_bytes < 85) begin
                if ($urandom_range(0, 3) == 0) build_broken_packet();
                else build_stream_packet();
                feed_packet();
            end
        end
        quiet_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_finds();
        test_error_statuses();
        test_random_traffic();
        wait_quiet();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: stall m_tready in random bursts.
    // ------------------------------------------------------------------
    initial begin : ready_stalls
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = idle_span();
            end
        end
    end

    // Compare every accepted result with the oldest one owed.
    always @(posedge aclk) begin : check_reports
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_reports.size() == 0) begin
                $error("result with none expected: status %0d", got.status);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got.found != want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    mismatch_count++;
                end
                if (got.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.hit_offset != want.hit_offset) begin
                    $error("hit_offset: expected %0d, actual %0d",
                           want.hit_offset, got.hit_offset);
                    mismatch_count++;
                end
                if (got.hit_length != want.hit_length) begin
                    $error("hit_length: expected %0d, actual %0d",
                           want.hit_length, got.hit_length);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
